// ===== rtl/assert_macros.svh =====
// Assertion macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every edge outside reset.
`define CBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every edge, reset included.
`define CBA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/cba_pkg.sv =====
`timescale 1ns / 1ps

package cba_pkg;

  localparam int MAX_BLOCKS = 1024;
  localparam int MAX_FILES  = 64;

  localparam int FIDX_W = $clog2(MAX_FILES);
  localparam int FCNT_W = FIDX_W + 1;
  localparam int NFB_W  = $clog2(MAX_BLOCKS) + 1;

  localparam int ID_W    = 16;
  localparam int SIZE_W  = 22;
  localparam int REC_W   = 13;
  localparam int BLK_W   = 10;
  localparam int CNT_W   = 11;
  localparam int STAT_W  = 3;
  localparam int DISK_W  = 11;
  localparam int BSIZE_W = 13;
  localparam int PROD_W  = DISK_W + BSIZE_W;

  localparam int DIV_STEPS = SIZE_W;
  localparam int DIVCNT_W  = $clog2(DIV_STEPS);

  localparam logic [STAT_W-1:0] ST_OK           = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE     = 3'd1;
  localparam logic [STAT_W-1:0] ST_TABLE_FULL   = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_RECORD   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_FILE      = 3'd4;
  localparam logic [STAT_W-1:0] ST_OUT_OF_RANGE = 3'd5;

  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic REG_DISK_BLOCKS = 1'b0;
  localparam logic REG_BLOCK_SIZE  = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [BLK_W-1:0]  start;
    logic [SIZE_W-1:0] size;
    logic [REC_W-1:0]  factor;
    logic [REC_W-1:0]  rec;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/contiguous_block_allocator.sv =====
`timescale 1ns / 1ps
// Contiguous block allocator with a file table.
// Request channel (req_valid/req_ready): mode 0 stores a file of size_kb with
// records of record_kb and grants floor(size_kb / block size) blocks from a
// bump pointer; mode 1 locates record_number of the first file with file_id.
// Response channel (rsp_valid/rsp_ready) carries one transfer per request:
// status, physical_block and block_count.
// The file table lives in one single-port RAM of 64 entries; a query reads
// the entries in turn, each read then compared, and every division runs on
// one shared restoring divider at one quotient bit per cycle. A store is
// checked, runs two divides and loads the output; a refused store goes from
// the check to the output. A query divides on its first match (the second
// divide only for a record in range); no match or an empty table skips them.
// One request is in flight at a time; a new one is taken as soon as the
// previous result sits in the output register, even if rsp_ready is low.
// A stalled receiver holds the output register and the finished request
// waits until it drains.
// Reset empties the table and the pointer at once, sets disk_blocks to 0 and
// block_size_kb to 1. Registers sit at APB byte addresses 0 and 4.

`include "assert_macros.svh"

module contiguous_block_allocator (
  input  logic        clk,
  input  logic        rst,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        req_valid,
  output logic        req_ready,
  input  logic        mode,
  input  logic [15:0] file_id,
  input  logic [21:0] size_kb,
  input  logic [12:0] record_kb,
  input  logic [21:0] record_number,

  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [2:0]  status,
  output logic [9:0]  physical_block,
  output logic [10:0] block_count
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_CMP   = 4'd3;
  localparam logic [3:0] S_DIVA  = 4'd4;
  localparam logic [3:0] S_DIVB  = 4'd5;
  localparam logic [3:0] S_OUT   = 4'd6;

  logic [3:0] state;

  logic [cba_pkg::DISK_W-1:0]  disk_blocks;
  logic [cba_pkg::BSIZE_W-1:0] block_size_kb;

  logic [cba_pkg::NFB_W-1:0]  nfb;
  logic [cba_pkg::FCNT_W-1:0] fcnt;
  logic [cba_pkg::FIDX_W-1:0] idx;

  logic                        mode_q;
  logic [cba_pkg::ID_W-1:0]    id_q;
  logic [cba_pkg::SIZE_W-1:0]  size_q;
  logic [cba_pkg::REC_W-1:0]   rec_q;
  logic [cba_pkg::SIZE_W-1:0]  recno_q;
  logic [cba_pkg::BSIZE_W-1:0] bsize_q;
  cba_pkg::entry_t             ent;

  logic [cba_pkg::STAT_W-1:0] res_status;
  logic [cba_pkg::BLK_W-1:0]  res_block;
  logic [cba_pkg::CNT_W-1:0]  res_count;

  logic [cba_pkg::SIZE_W-1:0]   dv_q;
  logic [cba_pkg::REC_W-1:0]    dv_rem;
  logic [cba_pkg::REC_W-1:0]    dv_dvs;
  logic [cba_pkg::DIVCNT_W-1:0] dv_cnt;

  logic [cba_pkg::REC_W:0]    dv_trial;
  logic                       dv_ge;
  logic [cba_pkg::REC_W-1:0]  dv_rem_next;
  logic [cba_pkg::SIZE_W-1:0] dv_q_next;
  logic                       dv_last;

  logic [cba_pkg::BSIZE_W-1:0] bsize_eff;
  logic [cba_pkg::DISK_W-1:0]  disk_eff;
  logic [cba_pkg::DISK_W-1:0]  remaining;
  logic [cba_pkg::PROD_W-1:0]  capacity;

  logic                        cfg_write;
  logic                        ram_we;
  logic [cba_pkg::FIDX_W-1:0]  ram_addr;
  cba_pkg::entry_t             ram_wdata;
  cba_pkg::entry_t             ram_rdata;
  logic                        out_load;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    if (paddr[2] == cba_pkg::REG_BLOCK_SIZE) begin
      prdata = {{(32 - cba_pkg::BSIZE_W){1'b0}}, block_size_kb};
    end else begin
      prdata = {{(32 - cba_pkg::DISK_W){1'b0}}, disk_blocks};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_blocks   <= '0;
      block_size_kb <= cba_pkg::BSIZE_W'(1);
    end else if (cfg_write) begin
      if (paddr[2] == cba_pkg::REG_BLOCK_SIZE) begin
        block_size_kb <= pwdata[cba_pkg::BSIZE_W-1:0];
      end else begin
        disk_blocks <= pwdata[cba_pkg::DISK_W-1:0];
      end
    end
  end

  assign bsize_eff = (block_size_kb == '0) ? cba_pkg::BSIZE_W'(1) : block_size_kb;
  assign disk_eff  = (disk_blocks > cba_pkg::DISK_W'(cba_pkg::MAX_BLOCKS))
                   ? cba_pkg::DISK_W'(cba_pkg::MAX_BLOCKS) : disk_blocks;
  assign remaining = (disk_eff > nfb) ? (disk_eff - nfb) : '0;
  assign capacity  = cba_pkg::PROD_W'(remaining) * cba_pkg::PROD_W'(bsize_eff);

  assign dv_trial    = {dv_rem, dv_q[cba_pkg::SIZE_W-1]};
  assign dv_ge       = dv_trial >= {1'b0, dv_dvs};
  assign dv_rem_next = dv_ge ? cba_pkg::REC_W'(dv_trial - {1'b0, dv_dvs})
                             : dv_trial[cba_pkg::REC_W-1:0];
  assign dv_q_next   = {dv_q[cba_pkg::SIZE_W-2:0], dv_ge};
  assign dv_last     = dv_cnt == cba_pkg::DIVCNT_W'(cba_pkg::DIV_STEPS - 1);

  assign req_ready = (state == S_IDLE) && !rst;
  assign out_load  = (state == S_OUT) && (!rsp_valid || rsp_ready);

  assign ram_we   = (state == S_DIVB) && dv_last && (mode_q == cba_pkg::MODE_STORE);
  assign ram_addr = ram_we ? fcnt[cba_pkg::FIDX_W-1:0] : idx;

  always_comb begin
    ram_wdata        = '0;
    ram_wdata.id     = id_q;
    ram_wdata.start  = nfb[cba_pkg::BLK_W-1:0];
    ram_wdata.size   = size_q;
    ram_wdata.factor = dv_q_next[cba_pkg::REC_W-1:0];
    ram_wdata.rec    = rec_q;
  end

  cba_ram #(
    .WIDTH (cba_pkg::ENTRY_W),
    .DEPTH (cba_pkg::MAX_FILES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      nfb   <= '0;
      fcnt  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            if (mode == cba_pkg::MODE_STORE) begin
              state <= S_CHECK;
            end else if (fcnt == '0) begin
              state <= S_OUT;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_CHECK: begin
          if (({2'b00, size_q} > capacity) ||
              (fcnt >= cba_pkg::FCNT_W'(cba_pkg::MAX_FILES)) ||
              (rec_q == '0) || (rec_q > bsize_eff)) begin
            state <= S_OUT;
          end else begin
            state <= S_DIVA;
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (ram_rdata.id == id_q) begin
            state <= S_DIVA;
          end else if ((cba_pkg::FCNT_W'(idx) + cba_pkg::FCNT_W'(1)) >= fcnt) begin
            state <= S_OUT;
          end else begin
            state <= S_RD;
          end
        end
        S_DIVA: begin
          if (dv_last) begin
            if ((mode_q == cba_pkg::MODE_QUERY) && (recno_q >= dv_q_next)) begin
              state <= S_OUT;
            end else begin
              state <= S_DIVB;
            end
          end
        end
        S_DIVB: begin
          if (dv_last) begin
            state <= S_OUT;
            if (mode_q == cba_pkg::MODE_STORE) begin
              nfb  <= nfb + cba_pkg::NFB_W'(res_count);
              fcnt <= fcnt + cba_pkg::FCNT_W'(1);
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        mode_q     <= mode;
        id_q       <= file_id;
        size_q     <= size_kb;
        rec_q      <= record_kb;
        recno_q    <= record_number;
        idx        <= '0;
        res_status <= cba_pkg::ST_NO_FILE;
        res_block  <= '0;
        res_count  <= '0;
      end
      S_CHECK: begin
        bsize_q <= bsize_eff;
        dv_q    <= size_q;
        dv_rem  <= '0;
        dv_dvs  <= bsize_eff;
        dv_cnt  <= '0;
        if ({2'b00, size_q} > capacity) begin
          res_status <= cba_pkg::ST_NO_SPACE;
        end else if (fcnt >= cba_pkg::FCNT_W'(cba_pkg::MAX_FILES)) begin
          res_status <= cba_pkg::ST_TABLE_FULL;
        end else if ((rec_q == '0) || (rec_q > bsize_eff)) begin
          res_status <= cba_pkg::ST_BAD_RECORD;
        end
      end
      S_CMP: begin
        ent    <= ram_rdata;
        dv_q   <= ram_rdata.size;
        dv_rem <= '0;
        dv_dvs <= (ram_rdata.rec == '0) ? cba_pkg::REC_W'(1) : ram_rdata.rec;
        dv_cnt <= '0;
        idx    <= idx + cba_pkg::FIDX_W'(1);
      end
      S_DIVA: begin
        dv_q   <= dv_q_next;
        dv_rem <= dv_rem_next;
        dv_cnt <= dv_cnt + cba_pkg::DIVCNT_W'(1);
        if (dv_last) begin
          dv_rem <= '0;
          dv_cnt <= '0;
          if (mode_q == cba_pkg::MODE_STORE) begin
            res_count <= dv_q_next[cba_pkg::CNT_W-1:0];
            dv_q      <= cba_pkg::SIZE_W'(bsize_q);
            dv_dvs    <= rec_q;
          end else begin
            res_status <= cba_pkg::ST_OUT_OF_RANGE;
            dv_q       <= recno_q;
            dv_dvs     <= (ent.factor == '0) ? cba_pkg::REC_W'(1) : ent.factor;
          end
        end
      end
      S_DIVB: begin
        dv_q   <= dv_q_next;
        dv_rem <= dv_rem_next;
        dv_cnt <= dv_cnt + cba_pkg::DIVCNT_W'(1);
        if (dv_last) begin
          res_status <= cba_pkg::ST_OK;
          if (mode_q == cba_pkg::MODE_STORE) begin
            res_block <= nfb[cba_pkg::BLK_W-1:0];
          end else begin
            res_block <= ent.start + dv_q_next[cba_pkg::BLK_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status         <= res_status;
      physical_block <= res_block;
      block_count    <= res_count;
    end
  end

  `CBA_ASSERT(a_nfb_bound, nfb <= cba_pkg::NFB_W'(cba_pkg::MAX_BLOCKS), "pointer past disk")
  `CBA_ASSERT(a_fcnt_bound, fcnt <= cba_pkg::FCNT_W'(cba_pkg::MAX_FILES), "table overfilled")
  `CBA_ASSERT(a_store_adds_one, ram_we |=> fcnt == $past(fcnt) + cba_pkg::FCNT_W'(1), "store lost")
  `CBA_ASSERT(a_div_nonzero, (state == S_DIVA || state == S_DIVB) |-> dv_dvs != '0, "zero divisor")
  `CBA_ASSERT(a_err_zero, (rsp_valid && status != cba_pkg::ST_OK) |-> (physical_block == '0 && block_count == '0), "error payload not cleared")
  `CBA_ASSERT_ALWAYS(a_rst_idle, rst |=> !rsp_valid, "response out of reset")

endmodule

// ===== rtl/cba_ram.sv =====
`timescale 1ns / 1ps

module cba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
